### hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, skipped while in reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, skipped while in reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/dcrpf_pkg.sv
// Shared types, constants and helper functions for the dot-crawl filter.
// No dependencies.
package dcrpf_pkg;

   localparam int PIXEL_BITS     = 8;
   localparam int SUM_BITS       = PIXEL_BITS + 1;
   localparam int CFG_BITS       = 8;
   localparam int CSR_INDEX_BITS = 8;

   typedef logic [PIXEL_BITS-1:0] pixel_type;
   typedef logic [SUM_BITS-1:0]   sum_type;
   typedef logic [CFG_BITS-1:0]   thresh_type;

   typedef enum logic {
      OP_LUMA   = 1'b0,
      OP_CHROMA = 1'b1
   } op_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_LUMA_SPATIAL  = 8'd0,
      REG_LUMA_TEMPORAL = 8'd1,
      REG_CHROMA_STABLE = 8'd2,
      REG_CHROMA_CHANGE = 8'd3
   } csr_index_type;

   localparam thresh_type LUMA_SPATIAL_RESET  = 8'd20;
   localparam thresh_type LUMA_TEMPORAL_RESET = 8'd20;
   localparam thresh_type CHROMA_STABLE_RESET = 8'd15;
   localparam thresh_type CHROMA_CHANGE_RESET = 8'd5;

   typedef struct packed {
      thresh_type luma_spatial;
      thresh_type luma_temporal;
      thresh_type chroma_stable;
      thresh_type chroma_change;
   } thresh_set_type;

   typedef struct packed {
      logic      op;
      logic      border;
      pixel_type center;
      pixel_type prev_one;
      pixel_type next_one;
      sum_type   lr_sum;
      sum_type   ab_sum;
      sum_type   center_x2;
      pixel_type d_pn;
      pixel_type d_cpp;
      pixel_type d_cnn;
      pixel_type d_cp;
      pixel_type d_cn;
   } front_type;

   typedef struct packed {
      logic      blend;
      pixel_type center;
      pixel_type partner;
   } decide_type;

   function automatic pixel_type pix_absdiff(input pixel_type a, input pixel_type b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

   function automatic sum_type sum_absdiff(input sum_type a, input sum_type b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

endpackage

### hw/rtl/dcrpf_if.sv
// Channel interfaces: pixel window request, filtered pixel response, register write.
// Depends on dcrpf_pkg.
interface dcrpf_req_if import dcrpf_pkg::*; ();
   logic      valid;
   logic      ready;
   logic      op;
   logic      border;
   pixel_type center;
   pixel_type left_pix;
   pixel_type right_pix;
   pixel_type above_two;
   pixel_type below_two;
   pixel_type prev_two;
   pixel_type prev_one;
   pixel_type next_one;
   pixel_type next_two;

   modport source (output valid, op, border, center, left_pix, right_pix, above_two,
                   below_two, prev_two, prev_one, next_one, next_two, input ready);
   modport sink   (input valid, op, border, center, left_pix, right_pix, above_two,
                   below_two, prev_two, prev_one, next_one, next_two, output ready);
endinterface

interface dcrpf_rsp_if import dcrpf_pkg::*; ();
   logic      valid;
   logic      ready;
   pixel_type out_pixel;

   modport source (output valid, out_pixel, input ready);
   modport sink   (input valid, out_pixel, output ready);
endinterface

interface dcrpf_csr_if import dcrpf_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   thresh_type                data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### hw/rtl/dot_crawl_rainbow_pixel_filter_top.sv
// Dot-crawl and rainbow filter, one pixel window in and one filtered pixel out per
// beat. It sustains one beat per clock unless the response side stalls; a result
// passes through three register stages (sums and differences, threshold tests,
// average and output register) after its window is accepted. Each stage holds its
// beat while the next one is full, so a stall on the response side back-pressures
// the request side without losing beats. Threshold registers are written through
// the register channel and should only change while no beat is in flight.
module dot_crawl_rainbow_pixel_filter_top import dcrpf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   dcrpf_req_if.sink   req_bus,
   dcrpf_rsp_if.source rsp_bus,
   dcrpf_csr_if.sink   csr_bus
);

   thresh_set_type thresh;
   logic           front_valid;
   logic           front_ready;
   front_type      front_data;
   logic           decide_valid;
   logic           decide_ready;
   decide_type     decide_data;

   dcrpf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .thresh  (thresh)
   );

   dcrpf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .out_valid (front_valid),
      .out_ready (front_ready),
      .out_data  (front_data)
   );

   dcrpf_decide u_decide (
      .clock     (clock),
      .reset     (reset),
      .thresh    (thresh),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_data   (front_data),
      .out_valid (decide_valid),
      .out_ready (decide_ready),
      .out_data  (decide_data)
   );

   dcrpf_blend u_blend (
      .clock    (clock),
      .reset    (reset),
      .in_valid (decide_valid),
      .in_ready (decide_ready),
      .in_data  (decide_data),
      .rsp_bus  (rsp_bus)
   );

endmodule

### hw/rtl/dcrpf_csr.sv
// Threshold register bank written through the register write channel.
// Depends on dcrpf_pkg and dcrpf_if.
module dcrpf_csr import dcrpf_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   dcrpf_csr_if.sink      csr_bus,
   output thresh_set_type thresh
);

   thresh_set_type thresh_ff;
   thresh_set_type thresh_in;

   assign csr_bus.ready = 1'b1;
   assign thresh        = thresh_ff;

   always_comb begin
      thresh_in = thresh_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            REG_LUMA_SPATIAL:  thresh_in.luma_spatial  = csr_bus.data;
            REG_LUMA_TEMPORAL: thresh_in.luma_temporal = csr_bus.data;
            REG_CHROMA_STABLE: thresh_in.chroma_stable = csr_bus.data;
            REG_CHROMA_CHANGE: thresh_in.chroma_change = csr_bus.data;
            default:           thresh_in = thresh_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff.luma_spatial  <= LUMA_SPATIAL_RESET;
         thresh_ff.luma_temporal <= LUMA_TEMPORAL_RESET;
         thresh_ff.chroma_stable <= CHROMA_STABLE_RESET;
         thresh_ff.chroma_change <= CHROMA_CHANGE_RESET;
      end else begin
         thresh_ff <= thresh_in;
      end
   end

endmodule

### hw/rtl/dcrpf_front.sv
// First pipeline stage: neighbour sums and temporal absolute differences.
// Depends on dcrpf_pkg and dcrpf_if.
module dcrpf_front import dcrpf_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   dcrpf_req_if.sink req_bus,
   output logic      out_valid,
   input  logic      out_ready,
   output front_type out_data
);

   logic      valid_ff;
   logic      valid_in;
   front_type data_ff;
   front_type data_in;
   logic      load;

   assign req_bus.ready = !valid_ff || out_ready;
   assign load          = req_bus.valid && req_bus.ready;
   assign valid_in      = load || (valid_ff && !out_ready);

   always_comb begin
      data_in.op        = req_bus.op;
      data_in.border    = req_bus.border;
      data_in.center    = req_bus.center;
      data_in.prev_one  = req_bus.prev_one;
      data_in.next_one  = req_bus.next_one;
      data_in.lr_sum    = SUM_BITS'(req_bus.left_pix) + SUM_BITS'(req_bus.right_pix);
      data_in.ab_sum    = SUM_BITS'(req_bus.above_two) + SUM_BITS'(req_bus.below_two);
      data_in.center_x2 = {req_bus.center, 1'b0};
      data_in.d_pn      = pix_absdiff(req_bus.prev_one, req_bus.next_one);
      data_in.d_cpp     = pix_absdiff(req_bus.center, req_bus.prev_two);
      data_in.d_cnn     = pix_absdiff(req_bus.center, req_bus.next_two);
      data_in.d_cp      = pix_absdiff(req_bus.center, req_bus.prev_one);
      data_in.d_cn      = pix_absdiff(req_bus.center, req_bus.next_one);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

### hw/rtl/dcrpf_decide.sv
// Second pipeline stage: threshold tests, blend decision and partner choice.
// Depends on dcrpf_pkg.
module dcrpf_decide import dcrpf_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  thresh_set_type thresh,
   input  logic           in_valid,
   output logic           in_ready,
   input  front_type      in_data,
   output logic           out_valid,
   input  logic           out_ready,
   output decide_type     out_data
);

   logic       valid_ff;
   logic       valid_in;
   decide_type data_ff;
   decide_type data_in;
   logic       load;
   logic       dots;
   logic       luma_stable;
   logic       chroma_stable;
   logic       chroma_change;
   logic       luma_hit;
   logic       chroma_hit;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;
   assign valid_in = load || (valid_ff && !out_ready);

   always_comb begin
      dots = (sum_absdiff(in_data.lr_sum, in_data.center_x2) >
              SUM_BITS'(thresh.luma_spatial)) ||
             (sum_absdiff(in_data.ab_sum, in_data.center_x2) >
              SUM_BITS'(thresh.luma_spatial));
      luma_stable = (in_data.d_pn  <= PIXEL_BITS'(thresh.luma_temporal)) &&
                    (in_data.d_cpp <= PIXEL_BITS'(thresh.luma_temporal)) &&
                    (in_data.d_cnn <= PIXEL_BITS'(thresh.luma_temporal));
      chroma_stable = (in_data.d_pn  <= PIXEL_BITS'(thresh.chroma_stable)) &&
                      (in_data.d_cpp <= PIXEL_BITS'(thresh.chroma_stable)) &&
                      (in_data.d_cnn <= PIXEL_BITS'(thresh.chroma_stable));
      chroma_change = (in_data.d_cp > PIXEL_BITS'(thresh.chroma_change)) &&
                      (in_data.d_cn > PIXEL_BITS'(thresh.chroma_change));
      luma_hit   = (in_data.op == OP_LUMA) && dots && luma_stable;
      chroma_hit = (in_data.op == OP_CHROMA) && chroma_stable && chroma_change;

      data_in.blend   = !in_data.border && (luma_hit || chroma_hit);
      data_in.center  = in_data.center;
      data_in.partner = (in_data.d_cn <= in_data.d_cp) ? in_data.next_one
                                                       : in_data.prev_one;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

### hw/rtl/dcrpf_blend.sv
// Third pipeline stage and output register: rounding average or pass-through.
// Depends on dcrpf_pkg and dcrpf_if.
module dcrpf_blend import dcrpf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  decide_type  in_data,
   dcrpf_rsp_if.source rsp_bus
);

   logic      valid_ff;
   logic      valid_in;
   pixel_type pixel_ff;
   pixel_type pixel_in;
   sum_type   pair_sum;
   sum_type   rounded;
   logic      load;

   assign in_ready = !valid_ff || rsp_bus.ready;
   assign load     = in_valid && in_ready;
   assign valid_in = load || (valid_ff && !rsp_bus.ready);

   always_comb begin
      pair_sum = SUM_BITS'(in_data.center) + SUM_BITS'(in_data.partner);
      rounded  = (pair_sum >> 1) + SUM_BITS'(pair_sum[0]);
      pixel_in = in_data.blend ? rounded[PIXEL_BITS-1:0] : in_data.center;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pixel_ff <= pixel_in;
      end
   end

   assign rsp_bus.valid     = valid_ff;
   assign rsp_bus.out_pixel = pixel_ff;

endmodule

### hw/rtl/dcrpf_checker.sv
// Port-level checks on the dot-crawl filter, bound to the top level.
// Depends on dcrpf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dcrpf_checker import dcrpf_pkg::*; (
   input logic      clock,
   input logic      reset,
   input logic      req_valid,
   input logic      req_ready,
   input logic      rsp_valid,
   input logic      rsp_ready,
   input pixel_type rsp_pixel
);

   logic req_beat;
   logic rsp_stall;

   assign req_beat  = req_valid && req_ready;
   assign rsp_stall = rsp_valid && !rsp_ready;

   `ASSERT_NEXT(a_rsp_valid_hold, clock, reset, rsp_stall, rsp_valid, "response dropped while stalled")
   `ASSERT_NEXT(a_rsp_pixel_hold, clock, reset, rsp_stall, $stable(rsp_pixel), "response pixel changed while stalled")
   `ASSERT_NEXT(a_empty_after_reset, clock, 1'b0, reset, !rsp_valid, "response valid straight after reset")
   `ASSERT_IMPLY(a_latency, clock, reset, $past(req_beat, 3) && !$past(reset, 3) && !$past(reset, 2) && !$past(reset, 1) && $past(rsp_ready, 2) && $past(rsp_ready, 1), rsp_valid, "beat not delivered after three free cycles")

endmodule

bind dot_crawl_rainbow_pixel_filter_top dcrpf_checker u_dcrpf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_pixel (rsp_bus.out_pixel)
);
